// ===== design/ssi_pkg.sv =====
package ssi_pkg;

    localparam int CAPACITY = 256;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int PRICE_W  = 32;
    localparam int INDEX_W  = 8;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = KEY_W + PRICE_W;
    localparam int M_DATA_W = INDEX_W;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_SRCH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic cmp_en;
        logic shift_en;
    } t_cell_ctl;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [PRICE_W-1:0]      price;
        logic                    below;
    } t_cell_link;

endpackage

// ===== design/sorted_table_search_insert.sv =====
// Channel   Dir  tdata (low bit up)              tuser
// s_axis    in   key[31:0], price[63:32]         op (0 lookup, 1 insert)
// m_axis    out  index[7:0]                      status (0 ok, 1 not found, 2 full)
//
// One request is in flight at a time; after acceptance the cells compare the key,
// then, unless an insert finds the table full, the binary search makes one probe
// per cycle over the compare flags held in the row of cells before the result is loaded.
// A finished request waits while the output register holds an untaken result;
// the next request is accepted while a result still waits in the output register.
// Reset clears the fill count, the controller and the output valid; entries are not cleared.
module sorted_table_search_insert (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [ssi_pkg::S_DATA_W-1:0]   s_axis_tdata,  // key, price
    input  logic                           s_axis_tuser,  // op
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [ssi_pkg::M_DATA_W-1:0]   m_axis_tdata,  // index
    output logic [ssi_pkg::STATUS_W-1:0]   m_axis_tuser   // status
);
    import ssi_pkg::*;

    t_cell_ctl               w_ctl;
    logic signed [KEY_W-1:0] w_key;
    logic [PRICE_W-1:0]      w_price;
    logic [CNT_W-1:0]        w_fill;
    logic [CAPACITY-1:0]     w_lt;
    logic [CAPACITY-1:0]     w_eq;
    logic [CAPACITY-1:0]     w_live;
    t_cell_link              w_link [CAPACITY];
    t_cell_link              w_head;

    assign w_head = '{key: '0, price: '0, below: 1'b1};

    ssi_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_ctl         (w_ctl),
        .o_key         (w_key),
        .o_price       (w_price),
        .o_fill        (w_fill),
        .i_lt          (w_lt),
        .i_eq          (w_eq)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_live[g] = (CNT_W'(g) < w_fill);
        if (g == 0) begin : g_first
            ssi_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_key   (w_key),
                .i_price (w_price),
                .i_live  (w_live[g]),
                .i_prev  (w_head),
                .o_link  (w_link[g]),
                .o_lt    (w_lt[g]),
                .o_eq    (w_eq[g])
            );
        end else begin : g_next
            ssi_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_key   (w_key),
                .i_price (w_price),
                .i_live  (w_live[g]),
                .i_prev  (w_link[g-1]),
                .o_link  (w_link[g]),
                .o_lt    (w_lt[g]),
                .o_eq    (w_eq[g])
            );
        end
    end

endmodule

// ===== design/ssi_cell.sv =====
module ssi_cell (
    input  logic                              i_clk,
    input  ssi_pkg::t_cell_ctl                i_ctl,
    input  logic signed [ssi_pkg::KEY_W-1:0]  i_key,
    input  logic [ssi_pkg::PRICE_W-1:0]       i_price,
    input  logic                              i_live,
    input  ssi_pkg::t_cell_link               i_prev,
    output ssi_pkg::t_cell_link               o_link,
    output logic                              o_lt,
    output logic                              o_eq
);
    import ssi_pkg::*;

    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] n_key;
    logic [PRICE_W-1:0]      r_price;
    logic [PRICE_W-1:0]      n_price;
    logic                    r_lt;
    logic                    r_eq;
    logic                    w_below;

    assign w_below = r_lt && i_live;

    always_comb begin
        n_key   = r_key;
        n_price = r_price;
        if (i_ctl.shift_en && !w_below) begin
            if (i_prev.below) begin
                n_key   = i_key;
                n_price = i_price;
            end else begin
                n_key   = i_prev.key;
                n_price = i_prev.price;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_price <= n_price;
        if (i_ctl.cmp_en) begin
            r_lt <= (r_key < i_key);
            r_eq <= (r_key == i_key);
        end
    end

    assign o_link = '{key: r_key, price: r_price, below: w_below};
    assign o_lt   = r_lt;
    assign o_eq   = r_eq;

endmodule

// ===== design/ssi_ctrl.sv =====
module ssi_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ssi_pkg::S_DATA_W-1:0]       s_axis_tdata,
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [ssi_pkg::M_DATA_W-1:0]       m_axis_tdata,
    output logic [ssi_pkg::STATUS_W-1:0]       m_axis_tuser,
    output ssi_pkg::t_cell_ctl                 o_ctl,
    output logic signed [ssi_pkg::KEY_W-1:0]   o_key,
    output logic [ssi_pkg::PRICE_W-1:0]        o_price,
    output logic [ssi_pkg::CNT_W-1:0]          o_fill,
    input  logic [ssi_pkg::CAPACITY-1:0]       i_lt,
    input  logic [ssi_pkg::CAPACITY-1:0]       i_eq
);
    import ssi_pkg::*;

    t_state                  r_state;
    t_state                  n_state;
    t_op                     r_op;
    logic signed [KEY_W-1:0] r_key;
    logic [PRICE_W-1:0]      r_price;
    logic [CNT_W-1:0]        r_fill;
    logic [CNT_W-1:0]        n_fill;
    logic [CNT_W-1:0]        r_lo;
    logic [CNT_W-1:0]        n_lo;
    logic [CNT_W-1:0]        r_he;
    logic [CNT_W-1:0]        n_he;
    t_status                 r_res_status;
    t_status                 n_res_status;
    logic [INDEX_W-1:0]      r_res_index;
    logic [INDEX_W-1:0]      n_res_index;
    logic                    r_out_valid;
    t_status                 r_out_status;
    logic [INDEX_W-1:0]      r_out_index;
    logic [CNT_W:0]          w_sum;
    logic [CNT_W-1:0]        w_mid;
    logic [IDX_W-1:0]        w_mid_idx;
    logic                    w_accept;
    logic                    w_load;

    assign w_accept  = s_axis_tvalid && s_axis_tready;
    assign w_sum     = {1'b0, r_lo} + {1'b0, r_he} - {{CNT_W{1'b0}}, 1'b1};
    assign w_mid     = w_sum[CNT_W:1];
    assign w_mid_idx = w_mid[IDX_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_lo         = r_lo;
        n_he         = r_he;
        n_res_status = r_res_status;
        n_res_index  = r_res_index;
        o_ctl        = '{cmp_en: 1'b0, shift_en: 1'b0};
        w_load       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                o_ctl.cmp_en = 1'b1;
                n_lo         = '0;
                n_he         = r_fill;
                if (r_op == OP_INSERT && r_fill == CNT_W'(CAPACITY)) begin
                    n_res_status = ST_FULL;
                    n_res_index  = '0;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (r_lo >= r_he) begin
                    n_state = S_DONE;
                    if (r_op == OP_INSERT) begin
                        o_ctl.shift_en = 1'b1;
                        n_fill         = r_fill + 1'b1;
                        n_res_status   = ST_OK;
                        n_res_index    = INDEX_W'(r_lo);
                    end else begin
                        n_res_status = ST_NOT_FOUND;
                        n_res_index  = '0;
                    end
                end else if (r_op == OP_LOOKUP && i_eq[w_mid_idx]) begin
                    n_res_status = ST_OK;
                    n_res_index  = INDEX_W'(w_mid);
                    n_state      = S_DONE;
                end else if (i_lt[w_mid_idx]) begin
                    n_lo = w_mid + 1'b1;
                end else begin
                    n_he = w_mid;
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= t_op'(s_axis_tuser);
            r_key   <= s_axis_tdata[KEY_W-1:0];
            r_price <= s_axis_tdata[S_DATA_W-1:KEY_W];
        end
        r_lo         <= n_lo;
        r_he         <= n_he;
        r_res_status <= n_res_status;
        r_res_index  <= n_res_index;
        if (w_load) begin
            r_out_status <= r_res_status;
            r_out_index  <= r_res_index;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_index;
    assign m_axis_tuser  = r_out_status;
    assign o_key         = r_key;
    assign o_price       = r_price;
    assign o_fill        = r_fill;

endmodule

// ===== design/ssi_checker.sv =====
module ssi_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [ssi_pkg::M_DATA_W-1:0]   m_axis_tdata,
    input logic [ssi_pkg::STATUS_W-1:0]   m_axis_tuser
);
    import ssi_pkg::*;

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // Only one request is in flight, so the input closes right after a request.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request accepted while one is in flight");

    // A failed request reports index zero.
    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == '0)
        else $error("nonzero index with a failing status");

    // While a result is offered, its status is one of the three defined codes.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_NOT_FOUND ||
                           m_axis_tuser == ST_FULL))
        else $error("undefined status code");

endmodule

bind sorted_table_search_insert ssi_checker u_ssi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ssi_pkg::*;

    localparam logic signed [KEY_W-1:0] KEY_LO = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_HI = 32'sh7FFF_FFFF;
    localparam int RANDOM_REQS = 600;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        t_op                     op;
        logic signed [KEY_W-1:0] key;
        logic [PRICE_W-1:0]      price;
    } t_table_req;

    typedef struct packed {
        t_status            status;
        logic [INDEX_W-1:0] index;
    } t_table_outcome;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata = '0;  // key[31:0], price[63:32]
    logic                  s_axis_tuser = 1'b0;  // op
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;  // index[7:0]
    logic [STATUS_W-1:0]   m_axis_tuser;  // status[1:0]

    sorted_table_search_insert DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    logic signed [KEY_W-1:0] row_keys [CAPACITY];
    logic [PRICE_W-1:0]      row_prices [CAPACITY];
    int                      row_fill = 0;

    t_table_req              req_backlog [$];
    t_table_outcome          outcome_queue [$];
    logic signed [KEY_W-1:0] known_keys [$];

    t_table_req     next_req;
    t_table_req     seen_req;
    t_table_outcome due_outcome;
    bit             req_taken = 1'b0;
    int             send_gap = 0;
    int             send_calm = 0;
    int             sink_hold = 0;
    int             sink_calm = 0;
    int             error_count = 0;

    function automatic t_table_outcome apply_table_op(t_table_req req);
        t_table_outcome res;
        int lo;
        int hi;
        int mid;
        int pos;
        int j;
        res.status = ST_NOT_FOUND;
        res.index = '0;
        if (req.op == OP_LOOKUP) begin
            lo = 0;
            hi = row_fill - 1;
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                if (row_keys[mid] == req.key) begin
                    res.status = ST_OK;
                    res.index = INDEX_W'(mid);
                    return res;
                end
                if ($signed(req.key) < $signed(row_keys[mid])) begin
                    hi = mid - 1;
                end else begin
                    lo = mid + 1;
                end
            end
        end else if (row_fill >= CAPACITY) begin
            res.status = ST_FULL;
        end else begin
            pos = 0;
            while (pos < row_fill && $signed(row_keys[pos]) < $signed(req.key)) begin
                pos++;
            end
            for (j = row_fill; j > pos; j--) begin
                row_keys[j] = row_keys[j-1];
                row_prices[j] = row_prices[j-1];
            end
            row_keys[pos] = req.key;
            row_prices[pos] = req.price;
            row_fill++;
            res.status = ST_OK;
            res.index = INDEX_W'(pos);
        end
        return res;
    endfunction

    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [KEY_W-1:0] edge_key();
        case ($urandom_range(0, 3))
            0: return KEY_LO;
            1: return KEY_HI;
            2: return -32'sd1;
            default: return 32'sd0;
        endcase
    endfunction

    function automatic logic [PRICE_W-1:0] some_price();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return '1;
        return $urandom();
    endfunction

    task automatic queue_req(t_op op, logic signed [KEY_W-1:0] key, logic [PRICE_W-1:0] price);
        t_table_req req;
        req.op = op;
        req.key = key;
        req.price = price;
        req_backlog.push_back(req);
        if (op == OP_INSERT) known_keys.push_back(key);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (req_taken || !s_axis_tvalid) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (req_backlog.size() > 0) begin
                    next_req = req_backlog.pop_front();
                    s_axis_tdata <= {next_req.price, next_req.key};
                    s_axis_tuser <= next_req.op;
                    s_axis_tvalid <= 1'b1;
                    send_gap = idle_len(send_calm);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            req_taken = 1'b0;
            if (sink_hold > 0) begin
                sink_hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                sink_hold = idle_len(sink_calm);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                seen_req.op = t_op'(s_axis_tuser);
                seen_req.key = s_axis_tdata[KEY_W-1:0];
                seen_req.price = s_axis_tdata[S_DATA_W-1:KEY_W];
                outcome_queue.push_back(apply_table_op(seen_req));
                req_taken = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (outcome_queue.size() == 0) begin
                    $error("result with no request outstanding: status %0d index %0d",
                           m_axis_tuser, m_axis_tdata);
                    error_count++;
                end else begin
                    due_outcome = outcome_queue.pop_front();
                    if (m_axis_tuser !== due_outcome.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               due_outcome.status, m_axis_tuser);
                        error_count++;
                    end
                    if (m_axis_tdata !== due_outcome.index) begin
                        $error("index mismatch: expected %0d, actual %0d",
                               due_outcome.index, m_axis_tdata);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        #(5_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic signed [KEY_W-1:0] k;
        int n;
        int r;

        // Lookups on the empty table, then extremes, duplicates and misses.
        queue_req(OP_LOOKUP, 32'sd0, '1);
        queue_req(OP_LOOKUP, KEY_LO, '0);
        queue_req(OP_INSERT, 32'sd0, '0);
        queue_req(OP_INSERT, KEY_HI, '1);
        queue_req(OP_INSERT, KEY_LO, 32'h5555_5555);
        queue_req(OP_INSERT, -32'sd1, 32'hAAAA_AAAA);
        queue_req(OP_INSERT, 32'sd0, 32'd1);
        queue_req(OP_INSERT, 32'sd0, 32'd2);
        queue_req(OP_INSERT, 32'sd5, '1);
        queue_req(OP_LOOKUP, 32'sd0, '0);
        queue_req(OP_LOOKUP, KEY_HI, '0);
        queue_req(OP_LOOKUP, KEY_LO, '0);
        queue_req(OP_LOOKUP, -32'sd1, '0);
        queue_req(OP_LOOKUP, 32'sd5, '0);
        queue_req(OP_LOOKUP, 32'sd1, '0);
        queue_req(OP_LOOKUP, KEY_HI - 32'sd1, '0);
        queue_req(OP_LOOKUP, KEY_LO + 32'sd1, '0);
        queue_req(OP_INSERT, KEY_HI, '0);
        queue_req(OP_LOOKUP, KEY_HI, '1);

        // Inserts dominate so the table fills and later inserts hit the full case.
        for (n = 0; n < RANDOM_REQS; n++) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 65) begin
                if (r < 25) k = known_keys[$urandom_range(0, known_keys.size() - 1)];
                else if (r < 32) k = edge_key();
                else k = $urandom();
                queue_req(OP_INSERT, k, some_price());
            end else begin
                if (r < 50) begin
                    k = known_keys[$urandom_range(0, known_keys.size() - 1)];
                end else if (r < 65) begin
                    k = known_keys[$urandom_range(0, known_keys.size() - 1)];
                    k = ($urandom_range(0, 1) != 0) ? k + 32'sd1 : k - 32'sd1;
                end else if (r < 72) begin
                    k = edge_key();
                end else begin
                    k = $urandom();
                end
                queue_req(OP_LOOKUP, k, some_price());
            end
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (req_backlog.size() != 0 || s_axis_tvalid || outcome_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
